// ===== rtl/isvt_pkg.sv =====
package isvt_pkg;

   typedef enum logic [2:0] {
      FN_GET        = 3'd0,
      FN_SET        = 3'd1,
      FN_PUSH_BACK  = 3'd2,
      FN_POP_BACK   = 3'd3,
      FN_PUSH_FRONT = 3'd4,
      FN_POP_FRONT  = 3'd5,
      FN_INSERT     = 3'd6,
      FN_DELETE     = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_CAPTURE,
      S_UP_RD,
      S_UP_WR,
      S_WRITE,
      S_DN_RD,
      S_DN_WR,
      S_RESP
   } state_type;

   // read address source
   typedef enum logic [2:0] {
      RD_POS,
      RD_LAST,
      RD_ZERO,
      RD_IDX_DN,
      RD_IDX_UP
   } rd_sel_type;

   // write address / data source
   typedef enum logic [1:0] {
      WR_POS_ITEM,
      WR_COUNT_ITEM,
      WR_ZERO_ITEM,
      WR_IDX_SHIFT
   } wr_sel_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_LOAD_COUNT,
      IDX_LOAD_POS,
      IDX_LOAD_ZERO,
      IDX_DEC,
      IDX_INC
   } idx_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef struct packed {
      logic       load_req;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       capture;
      logic       wr_en;
      wr_sel_type wr_sel;
      idx_op_type idx_op;
      cnt_op_type cnt_op;
      logic       rsp_load;
      status_type rsp_status;
      logic       rsp_use_read;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic full;
      logic empty;
      logic idx_gt_pos;
      logic idx_nonzero;
      logic dn_more;
   } sts_type;

endpackage

// ===== rtl/indexed_shift_vector_table.sv =====
// Ordered table of signed entries with a fill count.
// Request channel (req_*): func, position, item_value, one operation per
// transaction: get, set, push/pop back, push/pop front, insert, delete.
// Response channel (rsp_*): exactly one transaction per request, carrying
// the value read or popped, a status code, the count after the request and
// an empty flag. Failed requests leave the table untouched.
// Shifts move one entry at a time, with one RAM read and one RAM write per
// entry (the RAM has one port of each). One request in flight at a time:
// req_ready is high only while the controller is idle, so the next
// transaction can be accepted in the same cycle that rsp_valid rises.
// Reset clears the count and the handshake state; RAM contents are not
// cleared, entries at or past the count are never read.
// Receiver stall: a finished response sits in the output register; the
// block still accepts the next request and works on it, and only holds off
// loading its response until the pending one is taken.
module indexed_shift_vector_table #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [2:0]                 req_func,
   input  logic [$clog2(DEPTH)-1:0]   req_position,
   input  logic [DATA_WIDTH-1:0]      req_item_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [DATA_WIDTH-1:0]      rsp_read_value,
   output logic [1:0]                 rsp_status,
   output logic [$clog2(DEPTH+1)-1:0] rsp_count,
   output logic                       rsp_is_empty
);

   import isvt_pkg::*;

   cmd_type cmd;  // controller -> datapath
   sts_type sts;  // datapath -> controller flags

   // sequencer: request decode, shift loops, response hand-off
   isvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // entry RAM, count, shift index and response registers
   isvt_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .rsp_is_empty   (rsp_is_empty)
   );

endmodule

// ===== rtl/isvt_ram.sv =====
module isvt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/isvt_ctrl.sv =====
module isvt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_func,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output isvt_pkg::cmd_type cmd,
   input  isvt_pkg::sts_type sts
);

   import isvt_pkg::*;

   state_type  state_ff, state_in;
   func_type   func_ff, func_in;
   status_type err_ff, err_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       up_more;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff <= func_in;
      err_ff  <= err_in;
   end

   // shift-up stops at slot 0 for push front, at the insert point otherwise
   assign up_more = (func_ff == FN_PUSH_FRONT) ? sts.idx_nonzero : sts.idx_gt_pos;

   always_comb begin
      state_in         = state_ff;
      func_in          = func_ff;
      err_in           = err_ff;
      req_ready        = 1'b0;
      cmd.load_req     = 1'b0;
      cmd.rd_en        = 1'b0;
      cmd.rd_sel       = RD_POS;
      cmd.capture      = 1'b0;
      cmd.wr_en        = 1'b0;
      cmd.wr_sel       = WR_POS_ITEM;
      cmd.idx_op       = IDX_HOLD;
      cmd.cnt_op       = CNT_HOLD;
      cmd.rsp_load     = 1'b0;
      cmd.rsp_status   = err_ff;
      cmd.rsp_use_read = (err_ff == ST_OK) &&
                         (func_ff == FN_GET || func_ff == FN_POP_BACK ||
                          func_ff == FN_POP_FRONT);

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in      = func_type'(req_func);
               err_in       = ST_OK;
               cmd.load_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            unique case (func_ff)
               FN_GET: begin
                  if (sts.in_range) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_POS;
                     state_in   = S_CAPTURE;
                  end else begin
                     err_in   = ST_RANGE;
                     state_in = S_RESP;
                  end
               end
               FN_SET: begin
                  if (sts.in_range) begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = WR_POS_ITEM;
                  end else begin
                     err_in = ST_RANGE;
                  end
                  state_in = S_RESP;
               end
               FN_PUSH_BACK: begin
                  if (sts.full) begin
                     err_in = ST_FULL;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = WR_COUNT_ITEM;
                     cmd.cnt_op = CNT_INC;
                  end
                  state_in = S_RESP;
               end
               FN_POP_BACK: begin
                  if (sts.empty) begin
                     err_in   = ST_EMPTY;
                     state_in = S_RESP;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_LAST;
                     state_in   = S_CAPTURE;
                  end
               end
               FN_PUSH_FRONT: begin
                  if (sts.full) begin
                     err_in   = ST_FULL;
                     state_in = S_RESP;
                  end else begin
                     cmd.idx_op = IDX_LOAD_COUNT;
                     state_in   = S_UP_RD;
                  end
               end
               FN_POP_FRONT: begin
                  if (sts.empty) begin
                     err_in   = ST_EMPTY;
                     state_in = S_RESP;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_ZERO;
                     state_in   = S_CAPTURE;
                  end
               end
               FN_INSERT: begin
                  if (!sts.in_range) begin
                     err_in   = ST_RANGE;
                     state_in = S_RESP;
                  end else if (sts.full) begin
                     err_in   = ST_FULL;
                     state_in = S_RESP;
                  end else begin
                     cmd.idx_op = IDX_LOAD_COUNT;
                     state_in   = S_UP_RD;
                  end
               end
               FN_DELETE: begin
                  if (!sts.in_range) begin
                     err_in   = ST_RANGE;
                     state_in = S_RESP;
                  end else begin
                     cmd.idx_op = IDX_LOAD_POS;
                     state_in   = S_DN_RD;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_CAPTURE: begin
            cmd.capture = 1'b1;
            case (func_ff)
               FN_POP_BACK: begin
                  cmd.cnt_op = CNT_DEC;
                  state_in   = S_RESP;
               end
               FN_POP_FRONT: begin
                  cmd.idx_op = IDX_LOAD_ZERO;
                  state_in   = S_DN_RD;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_UP_RD: begin
            if (up_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX_DN;
               state_in   = S_UP_WR;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_UP_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_IDX_SHIFT;
            cmd.idx_op = IDX_DEC;
            state_in   = S_UP_RD;
         end
         S_WRITE: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = (func_ff == FN_PUSH_FRONT) ? WR_ZERO_ITEM : WR_POS_ITEM;
            cmd.cnt_op = CNT_INC;
            state_in   = S_RESP;
         end
         S_DN_RD: begin
            if (sts.dn_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX_UP;
               state_in   = S_DN_WR;
            end else begin
               cmd.cnt_op = CNT_DEC;
               state_in   = S_RESP;
            end
         end
         S_DN_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_IDX_SHIFT;
            cmd.idx_op = IDX_INC;
            state_in   = S_DN_RD;
         end
         S_RESP: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/isvt_dpath.sv =====
module isvt_dpath #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [$clog2(DEPTH)-1:0]     req_position,
   input  logic [DATA_WIDTH-1:0]        req_item_value,
   input  isvt_pkg::cmd_type            cmd,
   output isvt_pkg::sts_type            sts,
   output logic [DATA_WIDTH-1:0]        rsp_read_value,
   output logic [1:0]                   rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_count,
   output logic                         rsp_is_empty
);

   import isvt_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [AW-1:0]         pos_ff;
   logic [DATA_WIDTH-1:0] item_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [DATA_WIDTH-1:0] hold_ff;
   logic [DATA_WIDTH-1:0] rsp_value_ff;
   logic [1:0]            rsp_status_ff;
   logic [CW-1:0]         rsp_count_ff;
   logic                  rsp_empty_ff;

   logic [CW-1:0]         pos_ext;
   logic [CW-1:0]         rd_idx;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] rd_data;

   assign pos_ext = CW'(pos_ff);

   // status toward the controller
   assign sts.in_range    = pos_ext < count_ff;
   assign sts.full        = count_ff == CW'(DEPTH);
   assign sts.empty       = count_ff == '0;
   assign sts.idx_gt_pos  = idx_ff > pos_ext;
   assign sts.idx_nonzero = idx_ff != '0;
   assign sts.dn_more     = ({1'b0, idx_ff} + (CW+1)'(1)) < {1'b0, count_ff};

   always_comb begin
      case (cmd.rd_sel)
         RD_POS:    rd_idx = pos_ext;
         RD_LAST:   rd_idx = count_ff - CW'(1);
         RD_ZERO:   rd_idx = '0;
         RD_IDX_DN: rd_idx = idx_ff - CW'(1);
         RD_IDX_UP: rd_idx = idx_ff + CW'(1);
         default:   rd_idx = '0;
      endcase
      rd_addr = rd_idx[AW-1:0];

      case (cmd.wr_sel)
         WR_POS_ITEM: begin
            wr_addr = pos_ff;
            wr_data = item_ff;
         end
         WR_COUNT_ITEM: begin
            wr_addr = count_ff[AW-1:0];
            wr_data = item_ff;
         end
         WR_ZERO_ITEM: begin
            wr_addr = '0;
            wr_data = item_ff;
         end
         default: begin
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data;
         end
      endcase

      case (cmd.idx_op)
         IDX_LOAD_COUNT: idx_in = count_ff;
         IDX_LOAD_POS:   idx_in = pos_ext;
         IDX_LOAD_ZERO:  idx_in = '0;
         IDX_DEC:        idx_in = idx_ff - CW'(1);
         IDX_INC:        idx_in = idx_ff + CW'(1);
         default:        idx_in = idx_ff;
      endcase

      case (cmd.cnt_op)
         CNT_INC: count_in = count_ff + CW'(1);
         CNT_DEC: count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
      if (cmd.load_req) begin
         pos_ff  <= req_position;
         item_ff <= req_item_value;
      end
      if (cmd.capture) begin
         hold_ff <= rd_data;
      end
      if (cmd.rsp_load) begin
         rsp_value_ff  <= cmd.rsp_use_read ? hold_ff : '0;
         rsp_status_ff <= cmd.rsp_status;
         rsp_count_ff  <= count_ff;
         rsp_empty_ff  <= count_ff == '0;
      end
   end

   isvt_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_is_empty   = rsp_empty_ff;

endmodule

// ===== rtl/isvt_checker.sv =====
module isvt_checker #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [DATA_WIDTH-1:0]      rsp_read_value,
   input logic [1:0]                 rsp_status,
   input logic [$clog2(DEPTH+1)-1:0] rsp_count,
   input logic                       rsp_is_empty
);

   import isvt_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value) &&
      $stable(rsp_status) && $stable(rsp_count))
      else $error("stalled response changed");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_is_empty == (rsp_count == '0))
      else $error("empty flag disagrees with count");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_read_value == '0)
      else $error("failed request returned data");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= ($clog2(DEPTH+1))'(DEPTH))
      else $error("count past depth");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_count == ($clog2(DEPTH+1))'(DEPTH))
      else $error("full status with room left");

endmodule

bind indexed_shift_vector_table isvt_checker #(
   .DEPTH      (DEPTH),
   .DATA_WIDTH (DATA_WIDTH)
) u_isvt_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_read_value (rsp_read_value),
   .rsp_status     (rsp_status),
   .rsp_count      (rsp_count),
   .rsp_is_empty   (rsp_is_empty)
);
